// File: rtl/swm_pkg.sv
package swm_pkg;

  // Width of the window length register as seen on the config port
  localparam int unsigned CFG_LEN_BITS = 7;

  // Flags one cell shows its neighbors every cycle
  typedef struct packed {
    logic live;        // cell holds a window sample
    logic above;       // held value sorts after the incoming word (or cell is empty)
    logic drop;        // cell holds the oldest sample and leaves this step
    logic drop_below;  // some cell to the left leaves this step
  } cell_ctl_t;

endpackage

// File: rtl/swm_cell.sv
// One slot of the sorted window. Each step the slot keeps its sample, takes
// the one from its left or right neighbor, or takes the incoming word.
module swm_cell #(
  parameter int SAMPLE_BITS = 32,
  parameter int AGE_BITS    = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          step_i,
  input  logic                          full_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic        [AGE_BITS-1:0]    age_last_i,
  input  logic                          db_i,
  input  swm_pkg::cell_ctl_t            left_ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] left_val_i,
  input  logic        [AGE_BITS-1:0]    left_age_i,
  input  swm_pkg::cell_ctl_t            right_ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] right_val_i,
  input  logic        [AGE_BITS-1:0]    right_age_i,
  output swm_pkg::cell_ctl_t            ctl_o,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic        [AGE_BITS-1:0]    age_o,
  output logic                          db_o
);

  logic                          live_q, live_d;
  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic        [AGE_BITS-1:0]    age_q, age_d;
  logic                          take_left, take_self, take_right;

  // Flags for the neighbors
  always_comb begin
    ctl_o.live       = live_q;
    ctl_o.above      = !live_q || (val_q > x_i);
    ctl_o.drop       = full_i && live_q && (age_q == age_last_i);
    ctl_o.drop_below = db_i;
  end

  assign db_o  = db_i | ctl_o.drop;
  assign val_o = val_q;
  assign age_o = age_q;

  // Where this slot's next sample comes from: a sample moves up one slot when
  // the new word lands below it, down one slot when the leaving one is below it
  assign take_left  = left_ctl_i.above && !left_ctl_i.drop && !left_ctl_i.drop_below;
  assign take_self  = !ctl_o.drop && (ctl_o.above == db_i);
  assign take_right = right_ctl_i.drop_below && !right_ctl_i.above && !right_ctl_i.drop;

  always_comb begin
    if (take_left) begin
      live_d = left_ctl_i.live;
      val_d  = left_val_i;
      age_d  = left_age_i + AGE_BITS'(1);
    end else if (take_self) begin
      live_d = live_q;
      val_d  = val_q;
      age_d  = age_q + AGE_BITS'(1);
    end else if (take_right) begin
      live_d = right_ctl_i.live;
      val_d  = right_val_i;
      age_d  = right_age_i + AGE_BITS'(1);
    end else begin
      live_d = 1'b1;
      val_d  = x_i;
      age_d  = '0;
    end
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (clr_i) begin
      live_q <= 1'b0;
    end else if (step_i) begin
      live_q <= live_d;
    end
  end

  // Sample and age
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

endmodule

// File: rtl/sliding_window_median_unit.sv
// Sliding-window median filter.
// Input channel (in_valid_i/in_ready_o, sample_i) takes one signed word per
// accepted handshake. Output channel (out_valid_o/out_ready_i, median_o)
// gives the median of the last L words, the lower middle one for even L.
// Config channel (cfg_valid_i/cfg_ready_o, window_len_i) sets L; 0 acts as 1
// and values above WINDOW_MAX act as WINDOW_MAX. A write restarts the
// window; write only while the block is idle.
// No result is given until L words have entered since reset or the last
// config write; after that every word gives one result.
// Throughput: one word per cycle unless the receiver stalls. The window is a
// row of WINDOW_MAX sorted cells that drop the oldest word and insert the new
// one in the same cycle. Path of a result: the accepted word updates the cells,
// then the middle-cell select loads the output register.
// When the receiver stalls, one result waits in the output register and one
// more in the select stage; in_ready_o drops only when both are occupied.
// Reset: window empty, L = 1, no results pending. No clearing pass is run.
module sliding_window_median_unit #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [swm_pkg::CFG_LEN_BITS-1:0]     window_len_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        median_o
);

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = (LW > swm_pkg::CFG_LEN_BITS) ? LW : swm_pkg::CFG_LEN_BITS;

  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] fill_q;
  logic [LW-1:0] len_m1;
  logic [IW-1:0] mid;
  logic [CW-1:0] wl_ext;
  logic          cfg_fire, in_fire, load_out, full, res;
  logic          pend_q, out_valid_q;
  logic signed [SAMPLE_BITS-1:0] median_q;

  swm_pkg::cell_ctl_t            ctl  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cval [WINDOW_MAX];
  logic        [IW-1:0]          cage [WINDOW_MAX];
  logic                          db   [WINDOW_MAX+1];
  logic [WINDOW_MAX-1:0]         live_vec, drop_vec;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign load_out    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !pend_q || load_out;
  assign in_fire     = in_valid_i && in_ready_o;

  // Clamp the written length to 1..WINDOW_MAX
  assign wl_ext = CW'(window_len_i);
  always_comb begin
    if (wl_ext == '0) begin
      len_d = LW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      len_d = LW'(WINDOW_MAX);
    end else begin
      len_d = LW'(wl_ext);
    end
  end

  assign len_m1 = len_q - LW'(1);
  assign mid    = IW'(len_m1 >> 1);
  assign full   = (fill_q == len_q);
  assign res    = full || (({1'b0, fill_q} + (LW+1)'(1)) == {1'b0, len_q});

  // Window length and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LW'(1);
      fill_q <= '0;
    end else if (cfg_fire) begin
      len_q  <= len_d;
      fill_q <= '0;
    end else if (in_fire && !full) begin
      fill_q <= fill_q + LW'(1);
    end
  end

  // Row of sorted cells, oldest-drop chain runs left to right
  assign db[0] = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_pkg::cell_ctl_t            lctl, rctl;
    logic signed [SAMPLE_BITS-1:0] lval, rval;
    logic        [IW-1:0]          lage, rage;

    if (i == 0) begin : g_left_edge
      assign lctl = '{live: 1'b0, above: 1'b0, drop: 1'b0, drop_below: 1'b0};
      assign lval = '0;
      assign lage = '0;
    end else begin : g_left
      assign lctl = ctl[i-1];
      assign lval = cval[i-1];
      assign lage = cage[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_right_edge
      assign rctl = '{live: 1'b0, above: 1'b1, drop: 1'b0, drop_below: db[WINDOW_MAX]};
      assign rval = '0;
      assign rage = '0;
    end else begin : g_right
      assign rctl = ctl[i+1];
      assign rval = cval[i+1];
      assign rage = cage[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (IW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clr_i       (cfg_fire),
      .step_i      (in_fire),
      .full_i      (full),
      .x_i         (sample_i),
      .age_last_i  (len_m1[IW-1:0]),
      .db_i        (db[i]),
      .left_ctl_i  (lctl),
      .left_val_i  (lval),
      .left_age_i  (lage),
      .right_ctl_i (rctl),
      .right_val_i (rval),
      .right_age_i (rage),
      .ctl_o       (ctl[i]),
      .val_o       (cval[i]),
      .age_o       (cage[i]),
      .db_o        (db[i+1])
    );

    assign live_vec[i] = ctl[i].live;
    assign drop_vec[i] = ctl[i].drop;
  end

  // Result pending: middle cell is read into the output register once it can load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_q <= res;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= pend_q;
      end
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (load_out && pend_q) begin
      median_q <= cval[mid];
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  // Occupied cells track the fill level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live_vec) == int'(fill_q))
    else $error("cell occupancy differs from fill level");

  // Fill level never passes the window length
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= len_q)
    else $error("fill level above window length");

  // A full window drops exactly one cell per word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && full) |-> $onehot(drop_vec))
    else $error("full window without a single oldest cell");

  // No drop while the window is still filling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (drop_vec == '0))
    else $error("cell dropped before window is full");

  // A word that does not complete the window raises no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !res && !cfg_fire) |=> !pend_q)
    else $error("result raised before window is full");

endmodule

// File: tb/tb_sliding_window_median_unit.sv
module tb_sliding_window_median_unit;

  localparam int WIN_MAX   = 64;
  localparam int SMP_BITS  = 32;
  localparam int LEN_BITS  = swm_pkg::CFG_LEN_BITS;
  localparam int LONG_HOLD = 150;
  localparam int ITEM_GOAL = 1350;

  // pace of both sides for the current phase
  localparam int PACE_NONE  = 0;
  localparam int PACE_LIGHT = 1;
  localparam int PACE_HEAVY = 2;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       cfg_valid_i  = 1'b0;
  logic                       cfg_ready_o;
  logic [LEN_BITS-1:0]        window_len_i = '0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic signed [SMP_BITS-1:0] sample_i     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic signed [SMP_BITS-1:0] median_o;

  // request from the sequencer for one long output stall
  logic                       long_hold_go = 1'b0;

  sliding_window_median_unit #(
    .WINDOW_MAX (WIN_MAX),
    .SAMPLE_BITS(SMP_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .window_len_i(window_len_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .median_o    (median_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [SMP_BITS-1:0] pending_samples[$];
  logic signed [SMP_BITS-1:0] medians_due[$];

  // filter state mirrored in the bench
  logic signed [SMP_BITS-1:0] win_hist[WIN_MAX];
  logic [LEN_BITS-1:0]        win_len_reg = 7'd1;
  int                         win_slot    = 0;
  int                         win_fill    = 0;

  logic signed [SMP_BITS-1:0] prev_draw = '0;
  int pace        = PACE_LIGHT;
  int errors      = 0;
  int words_in    = 0;
  int medians_out = 0;
  int settings    = 1;

  function automatic int eff_len(input logic [LEN_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return int'(v);
  endfunction

  // idle cycles before the next word on either side
  function automatic int draw_idle();
    if (pace == PACE_NONE) return 0;
    if (pace == PACE_LIGHT && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  // mix of full-range values, clustered small values (duplicates), extremes
  function automatic logic signed [SMP_BITS-1:0] draw_sample();
    logic signed [SMP_BITS-1:0] v;
    int r;
    r = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $signed($urandom_range(0, 8)) - 4;
      7:          v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      8:          v = $urandom_range(0, 1) ? 32'sh7fffffff - r : 32'sh80000000 + r;
      default:    v = prev_draw;
    endcase
    prev_draw = v;
    return v;
  endfunction

  // window update; once full, queue the lower-middle element of the sorted window
  task automatic filter_sample(input logic signed [SMP_BITS-1:0] s);
    logic signed [SMP_BITS-1:0] srt[WIN_MAX];
    logic signed [SMP_BITS-1:0] key;
    int n;
    int j;
    n = eff_len(win_len_reg);
    win_hist[win_slot] = s;
    win_slot = (win_slot + 1) % n;
    if (win_fill < n) win_fill++;
    if (win_fill == n) begin
      for (int i = 0; i < n; i++) begin
        key = win_hist[i];
        j = i - 1;
        while (j >= 0 && srt[j] > key) begin
          srt[j+1] = srt[j];
          j--;
        end
        srt[j+1] = key;
      end
      medians_due = {medians_due, srt[(n - 1) / 2]};
    end
  endtask

  // input driver: one word from the pending queue per handshake
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) filter_sample(sample_i);
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_valid_i <= 1'b1;
        sample_i   <= pending_samples.pop_front();
        in_gap = draw_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor: compare each median with the oldest expected one
  int rx_hold = 0;
  always @(posedge clk_i) begin
    logic signed [SMP_BITS-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        medians_out++;
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected median %0d, none expected", $time, median_o);
          errors++;
        end else begin
          want = medians_due.pop_front();
          if (median_o !== want) begin
            $display("%0t: median mismatch, expected %0d, actual %0d",
                     $time, want, median_o);
            errors++;
          end
        end
        rx_hold = draw_idle();
      end
      if (long_hold_go) rx_hold = LONG_HOLD;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // config write; only called while the block is idle
  task automatic write_len(input logic [LEN_BITS-1:0] v);
    cfg_valid_i  <= 1'b1;
    window_len_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_len_reg = v;
    win_slot    = 0;
    win_fill    = 0;
    settings++;
  endtask

  // wait until every word went in and every median came out, plus pipeline slack
  task automatic settle();
    while (pending_samples.size() != 0 || in_valid_i || medians_due.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic push_word(input logic signed [SMP_BITS-1:0] v);
    pending_samples = {pending_samples, v};
    words_in++;
  endtask

  initial begin
    logic [LEN_BITS-1:0] fixed_lens[4];
    logic [LEN_BITS-1:0] len_pick;
    int k;
    int n;
    fixed_lens = '{7'd127, 7'd64, 7'd63, 7'd32};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset length of one: every word is its own median
    pace = PACE_LIGHT;
    push_word(32'sh80000000);
    push_word(32'sh7fffffff);
    push_word(32'sh00000000);
    push_word(-32'sd1);
    push_word(32'sd1);
    push_word(32'sh55555555);
    push_word(32'shaaaaaaaa);
    settle();

    // zero length behaves as one
    write_len(7'd0);
    push_word(-32'sd5);
    push_word(32'sd5);
    push_word(32'sh80000000);
    settle();

    // even window picks the lower middle
    write_len(7'd2);
    push_word(32'sh7fffffff);
    push_word(32'sh80000000);
    push_word(-32'sd1);
    push_word(32'sd0);
    push_word(32'sd0);
    settle();

    // repeated values: only one copy leaves with the oldest word
    write_len(7'd3);
    push_word(32'sd4);
    push_word(32'sd4);
    push_word(-32'sd7);
    push_word(32'sd4);
    push_word(-32'sd7);
    push_word(-32'sd7);
    settle();

    // output held off for a long stretch while the input keeps offering words
    write_len(7'd5);
    pace = PACE_NONE;
    long_hold_go <= 1'b1;
    for (int i = 0; i < 200; i++) push_word(draw_sample());
    @(posedge clk_i);
    long_hold_go <= 1'b0;
    settle();

    // random phases: clamped and boundary lengths first, then mostly short windows
    k = 0;
    while (words_in < ITEM_GOAL) begin
      if (k < 4) len_pick = fixed_lens[k];
      else if ($urandom_range(0, 9) < 7) len_pick = $urandom_range(1, 9);
      else len_pick = $urandom_range(0, 127);
      pace = $urandom_range(PACE_NONE, PACE_HEAVY);
      write_len(len_pick);
      n = eff_len(len_pick) + $urandom_range(8, 60);
      for (int i = 0; i < n; i++) push_word(draw_sample());
      settle();
      k++;
    end

    repeat (10) @(posedge clk_i);
    $display("Ran %0d samples over %0d window settings (zero, one, even, odd, 64, clamped)",
             words_in, settings);
    $display("and checked %0d medians, with random gaps, bursts and a %0d-cycle output stall.",
             medians_out, LONG_HOLD);
    if (errors == 0 && medians_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: run did not complete in time", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
